// ===== rtl/core/rmst_pkg.sv =====
// Shared types and constants for the range minimum segment tree.
`timescale 1ns / 1ps

package rmst_pkg;

  // fixed widths of the channel payloads
  localparam int CMD_W = 2;
  localparam int POS_W = 10;
  localparam int OPV_W = 32;
  localparam int MIN_W = 32;
  localparam int CNT_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET   = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_LEAF,
    ST_CLIMB,
    ST_REPLY
  } state_t;

  // which child a walker keeps descending into once its range has split
  typedef enum logic {
    SIDE_LEFT,
    SIDE_RIGHT
  } side_t;

  typedef struct packed {
    logic  load;
    logic  abort;
    logic  split;
    side_t side;
  } walk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rd_en;
    logic hand_off;
  } walk_stat_t;

endpackage

// ===== rtl/core/rmst_if.sv =====
// Channel interfaces: command items, result items and the element count register.
`timescale 1ns / 1ps

interface rmst_cmd_if import rmst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [POS_W-1:0]        position;
  logic signed [OPV_W-1:0] operand_value;
  logic [POS_W-1:0]        range_low;
  logic [POS_W-1:0]        range_high;

  modport source (output valid, command, position, operand_value, range_low, range_high,
                  input ready);
  modport sink   (input valid, command, position, operand_value, range_low, range_high,
                  output ready);
endinterface

interface rmst_min_if import rmst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [MIN_W-1:0] minimum;

  modport source (output valid, minimum, input ready);
  modport sink   (input valid, minimum, output ready);
endinterface

interface rmst_cfg_if import rmst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] elements_in_use;

  modport source (output valid, elements_in_use, input ready);
  modport sink   (input valid, elements_in_use, output ready);
endinterface

// ===== rtl/core/rmst_walker.sv =====
// Tree walker: descends one level a cycle towards a point or an index span.
`timescale 1ns / 1ps

module rmst_walker import rmst_pkg::*; #(
  parameter int IDX_W  = 10,
  parameter int NODE_W = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  walk_ctrl_t        ctrl,
  input  logic [NODE_W-1:0] load_node,
  input  logic [IDX_W-1:0]  load_s,
  input  logic [IDX_W-1:0]  load_e,
  input  logic [IDX_W-1:0]  load_lo,
  input  logic [IDX_W-1:0]  load_hi,
  output walk_stat_t        stat,
  output logic [NODE_W-1:0] rd_node,
  output logic [NODE_W-1:0] hand_node,
  output logic [IDX_W-1:0]  hand_s,
  output logic [IDX_W-1:0]  hand_e,
  output logic [IDX_W-1:0]  hand_hi
);

  logic              active_r, active_nxt;
  logic              split_r, split_nxt;
  side_t             side_r, side_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [IDX_W-1:0]  s_r, s_nxt, e_r, e_nxt, lo_r, lo_nxt, hi_r, hi_nxt;

  logic [IDX_W:0]    sum;
  logic [IDX_W-1:0]  mid, mid_p1;
  logic              full, go_left, go_right, straddle, step_left;
  logic [NODE_W-1:0] left_node, right_node;

  assign sum        = {1'b0, s_r} + {1'b0, e_r};
  assign mid        = sum[IDX_W:1];
  assign mid_p1     = mid + IDX_W'(1);
  assign full       = (lo_r == s_r) && (hi_r == e_r);
  assign go_left    = hi_r <= mid;
  assign go_right   = lo_r > mid;
  assign straddle   = !go_left && !go_right;
  assign left_node  = {node_r[NODE_W-2:0], 1'b0};
  assign right_node = {node_r[NODE_W-2:0], 1'b1};
  // first split keeps the left part; afterwards each walker keeps its own side
  assign step_left  = go_left || (straddle && (!split_r || side_r == SIDE_LEFT));

  // a split walker reads the child that lies wholly inside the span
  assign stat.busy     = active_r;
  assign stat.done     = active_r && full;
  assign stat.rd_en    = active_r && (full || (straddle && split_r));
  assign stat.hand_off = active_r && !full && straddle && !split_r;

  assign rd_node   = full ? node_r : ((side_r == SIDE_LEFT) ? right_node : left_node);
  assign hand_node = right_node;
  assign hand_s    = mid_p1;
  assign hand_e    = e_r;
  assign hand_hi   = hi_r;

  always_comb begin
    active_nxt = active_r;
    split_nxt  = split_r;
    side_nxt   = side_r;
    node_nxt   = node_r;
    s_nxt      = s_r;
    e_nxt      = e_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    priority if (ctrl.abort) begin
      active_nxt = 1'b0;
    end else if (ctrl.load) begin
      active_nxt = 1'b1;
      split_nxt  = ctrl.split;
      side_nxt   = ctrl.side;
      node_nxt   = load_node;
      s_nxt      = load_s;
      e_nxt      = load_e;
      lo_nxt     = load_lo;
      hi_nxt     = load_hi;
    end else if (active_r) begin
      if (full) begin
        active_nxt = 1'b0;
      end else if (step_left) begin
        node_nxt  = left_node;
        e_nxt     = mid;
        split_nxt = split_r | straddle;
        if (hi_r > mid) begin
          hi_nxt = mid;
        end
      end else begin
        node_nxt = right_node;
        s_nxt    = mid_p1;
        if (lo_r <= mid) begin
          lo_nxt = mid_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      split_r  <= 1'b0;
      side_r   <= SIDE_LEFT;
    end else begin
      active_r <= active_nxt;
      split_r  <= split_nxt;
      side_r   <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
  end

endmodule

// ===== rtl/core/range_minimum_segment_tree.sv =====
// Top level: range minimum segment tree held in one dual-read block memory.
//
// in_ch  carries command items: set an element, add a delta to an element
//        (wrapping), or query the minimum over [range_low, range_high].
// out_ch carries one result item per query; set, add and the spare command
//        give none. An empty or out-of-range span returns the largest value.
// cfg_ch writes elements_in_use (clamped to 1..MAX_ELEMENTS); every write
//        clears the tree.
// The tree walk sets the rate. An update descends to the leaf, does a leaf
// read-modify-write and climbs back to the root level by level; a query
// has two walkers descend the span edges side by side, one memory read port
// each. in_ch takes one item at a time, whenever the sequencer is idle.
// Results sit in an output register; a stalled receiver holds only the next
// query at its reply step, so set and add items keep flowing meanwhile.
// After reset and after each cfg write a clearing pass over all
// 2*MAX_ELEMENTS slots fills the memory with the largest value; in_ch is
// held off then, cfg_ch stays ready. Reset is synchronous, active low.
`timescale 1ns / 1ps

module range_minimum_segment_tree import rmst_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_WIDTH  = 32
) (
  input logic         clk,
  input logic         rst_n,
  rmst_cmd_if.sink    in_ch,
  rmst_min_if.source  out_ch,
  rmst_cfg_if.sink    cfg_ch
);

  localparam int IW      = $clog2(MAX_ELEMENTS);
  localparam int NW      = IW + 2;
  localparam int SLOTS   = 2 * MAX_ELEMENTS;
  localparam int AW      = $clog2(SLOTS);
  localparam int CW      = $clog2(MAX_ELEMENTS + 1);
  localparam int EW      = (CW > CNT_W) ? CW : CNT_W;
  localparam int N_RESET = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  function automatic logic [VALUE_WIDTH-1:0] smin(input logic [VALUE_WIDTH-1:0] a,
                                                  input logic [VALUE_WIDTH-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

  // sequencer
  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt, in_cmd;
  logic [CW-1:0]           n_r, n_nxt;
  logic [AW-1:0]           clr_ptr_r, clr_ptr_nxt;
  logic [EW-1:0]           n_ext, pos_ext, lo_ext, hi_ext, cfg_ext, cfg_n;
  logic [IW-1:0]           n_last;

  // datapath
  logic [VALUE_WIDTH-1:0]  opv_r, opv_nxt, cur_val_r, cur_val_nxt, acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0]  a_term, b_term, ab_min, leaf_new, climb_min;
  logic [NW-1:0]           cur_node_r, cur_node_nxt, parent_node;
  logic signed [MIN_W-1:0] out_min_r, out_min_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // memory ports
  logic [VALUE_WIDTH-1:0]  tree_mem [SLOTS];
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [VALUE_WIDTH-1:0]  wr_data;
  logic                    rda_en;
  logic [NW-1:0]           rda_node;
  logic                    rd_a_vld_r, rd_a_ok_r, rd_b_vld_r, rd_b_ok_r;
  logic [VALUE_WIDTH-1:0]  rd_a_data_r, rd_b_data_r;

  // walkers
  walk_ctrl_t              a_ctrl, b_ctrl;
  walk_stat_t              a_stat, b_stat;
  logic [NW-1:0]           a_load_node, a_rd_node, a_hand_node, b_rd_node;
  logic [IW-1:0]           a_load_lo, a_load_hi, a_hand_s, a_hand_e, a_hand_hi;

  rmst_walker #(
    .IDX_W  (IW),
    .NODE_W (NW)
  ) u_walk_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (a_ctrl),
    .load_node (a_load_node),
    .load_s    ('0),
    .load_e    (n_last),
    .load_lo   (a_load_lo),
    .load_hi   (a_load_hi),
    .stat      (a_stat),
    .rd_node   (a_rd_node),
    .hand_node (a_hand_node),
    .hand_s    (a_hand_s),
    .hand_e    (a_hand_e),
    .hand_hi   (a_hand_hi)
  );

  // walker B takes over the right half of a span at its first split
  rmst_walker #(
    .IDX_W  (IW),
    .NODE_W (NW)
  ) u_walk_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (b_ctrl),
    .load_node (a_hand_node),
    .load_s    (a_hand_s),
    .load_e    (a_hand_e),
    .load_lo   (a_hand_s),
    .load_hi   (a_hand_hi),
    .stat      (b_stat),
    .rd_node   (b_rd_node),
    .hand_node (),
    .hand_s    (),
    .hand_e    (),
    .hand_hi   ()
  );

  assign in_cmd  = cmd_t'(in_ch.command);
  assign n_ext   = EW'(n_r);
  assign pos_ext = EW'(in_ch.position);
  assign lo_ext  = EW'(in_ch.range_low);
  assign hi_ext  = EW'(in_ch.range_high);
  assign cfg_ext = EW'(cfg_ch.elements_in_use);
  assign n_last  = IW'(n_r - CW'(1));

  // zero acts as one, anything past the store as the full store
  assign cfg_n = (cfg_ext == '0) ? EW'(1) :
                 (cfg_ext > EW'(MAX_ELEMENTS)) ? EW'(MAX_ELEMENTS) : cfg_ext;

  // unread or out-of-store nodes count as the largest value
  assign a_term      = (rd_a_vld_r && rd_a_ok_r) ? rd_a_data_r : VALUE_MAX;
  assign b_term      = (rd_b_vld_r && rd_b_ok_r) ? rd_b_data_r : VALUE_MAX;
  assign ab_min      = smin(a_term, b_term);
  assign leaf_new    = (cmd_r == CMD_ADD) ? (a_term + opv_r) : opv_r;
  assign parent_node = cur_node_r >> 1;
  assign climb_min   = smin(cur_val_r, a_term);

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.minimum = out_min_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    n_nxt         = n_r;
    clr_ptr_nxt   = clr_ptr_r;
    opv_nxt       = opv_r;
    cur_node_nxt  = cur_node_r;
    cur_val_nxt   = cur_val_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_min_nxt   = out_min_r;
    wr_en         = 1'b0;
    wr_addr       = clr_ptr_r;
    wr_data       = VALUE_MAX;
    rda_en        = a_stat.rd_en;
    rda_node      = a_rd_node;
    a_ctrl        = '{load: 1'b0, abort: 1'b0, split: 1'b0, side: SIDE_LEFT};
    b_ctrl        = '{load: a_stat.hand_off, abort: 1'b0, split: 1'b1, side: SIDE_RIGHT};
    a_load_node   = NW'(1);
    a_load_lo     = IW'(in_ch.position);
    a_load_hi     = IW'(in_ch.position);

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        clr_ptr_nxt = clr_ptr_r + AW'(1);
        if (clr_ptr_r == AW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_cmd;
          opv_nxt = VALUE_WIDTH'(in_ch.operand_value);
          unique case (in_cmd)
            CMD_SET, CMD_ADD: begin
              // positions past the element count are dropped
              if (pos_ext < n_ext) begin
                a_ctrl.load = 1'b1;
                state_nxt   = ST_WALK;
              end
            end
            CMD_QUERY: begin
              acc_nxt = VALUE_MAX;
              if ((in_ch.range_low > in_ch.range_high) || (lo_ext >= n_ext)) begin
                state_nxt = ST_REPLY;
              end else begin
                a_ctrl.load = 1'b1;
                a_load_lo   = IW'(in_ch.range_low);
                a_load_hi   = (hi_ext >= n_ext) ? n_last : IW'(in_ch.range_high);
                state_nxt   = ST_WALK;
              end
            end
            CMD_NOP: begin
              // spare code: no effect
            end
          endcase
        end
      end

      ST_WALK: begin
        if (cmd_r == CMD_QUERY) begin
          acc_nxt = smin(acc_r, ab_min);
          if (!a_stat.busy && !b_stat.busy) begin
            state_nxt = ST_REPLY;
          end
        end else if (a_stat.done) begin
          // walker is on the leaf and has just issued its read
          cur_node_nxt = a_rd_node;
          state_nxt    = ST_LEAF;
        end
      end

      ST_LEAF: begin
        wr_en       = (cur_node_r < NW'(SLOTS));
        wr_addr     = cur_node_r[AW-1:0];
        wr_data     = leaf_new;
        cur_val_nxt = leaf_new;
        rda_en      = 1'b0;
        rda_node    = cur_node_r ^ NW'(1);
        if (cur_node_r == NW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          rda_en    = 1'b1;
          state_nxt = ST_CLIMB;
        end
      end

      ST_CLIMB: begin
        // sibling arrives now; the child just written is held in cur_val_r
        wr_en        = (parent_node < NW'(SLOTS));
        wr_addr      = parent_node[AW-1:0];
        wr_data      = climb_min;
        cur_node_nxt = parent_node;
        cur_val_nxt  = climb_min;
        rda_en       = 1'b0;
        rda_node     = parent_node ^ NW'(1);
        if (parent_node == NW'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          rda_en = 1'b1;
        end
      end

      ST_REPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_min_nxt   = MIN_W'($signed(acc_r));
          state_nxt     = ST_IDLE;
        end
      end
    endcase

    // a count write restarts the clearing pass
    if (cfg_ch.valid) begin
      n_nxt        = CW'(cfg_n);
      clr_ptr_nxt  = '0;
      state_nxt    = ST_CLEAR;
      a_ctrl.abort = 1'b1;
      b_ctrl.abort = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      n_r         <= CW'(N_RESET);
      clr_ptr_r   <= '0;
      out_valid_r <= 1'b0;
      rd_a_vld_r  <= 1'b0;
      rd_b_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      out_valid_r <= out_valid_nxt;
      rd_a_vld_r  <= rda_en;
      rd_b_vld_r  <= b_stat.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    opv_r      <= opv_nxt;
    cur_node_r <= cur_node_nxt;
    cur_val_r  <= cur_val_nxt;
    acc_r      <= acc_nxt;
    out_min_r  <= out_min_nxt;
    rd_a_ok_r  <= (rda_node < NW'(SLOTS));
    rd_b_ok_r  <= (b_rd_node < NW'(SLOTS));
  end

  // tree store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    rd_a_data_r <= tree_mem[rda_node[AW-1:0]];
    rd_b_data_r <= tree_mem[b_rd_node[AW-1:0]];
  end

`ifndef SYNTHESIS
  a_reply_only_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == ST_REPLY))
    else $error("result raised outside the reply step");

  a_no_split_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && cmd_r != CMD_QUERY) |-> !b_stat.busy)
    else $error("second walker active during an update");

  a_climb_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLIMB) |-> (cur_node_r != NW'(1)))
    else $error("climb step entered at the root");

  a_writes_in_place: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_CLEAR || state_r == ST_LEAF || state_r == ST_CLIMB))
    else $error("tree written outside clear or update");
`endif

endmodule
